>>> rtl/crv_pkg.sv
// shared definitions for the cordic rotate/vector block
// register codes, configuration struct and the arctangent constant builder
// no dependencies
package crv_pkg;

  localparam int ITERATIONS      = 16;
  localparam int MAX_SCALE_STEPS = 4;
  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;

  localparam int FIELD_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;
  localparam int COUNT_W     = 3;
  localparam int SHIFT_W     = 5;
  localparam int SCALE_REGS  = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET   = 3'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_A_RESET = 5'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_B_RESET = 5'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_C_RESET = 5'd6;
  localparam logic [SHIFT_W-1:0] SHIFT_D_RESET = 5'd9;

  // pi/4 with 60 fraction bits
  localparam logic [63:0] PI_QUARTER_Q60 = 64'h0C90_FDAA_2216_8C23;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_COUNT = 3'd0,
    REG_SHIFT_A    = 3'd1,
    REG_SHIFT_B    = 3'd2,
    REG_SHIFT_C    = 3'd3,
    REG_SHIFT_D    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                   step_count;
    logic [SCALE_REGS-1:0][SHIFT_W-1:0]   shift;
  } cfg_t;

  // division by a small odd constant, elaboration only
  function automatic logic [63:0] odd_div(input logic [63:0] v, input int unsigned k);
    case (k)
      3:  return v / 3;   5:  return v / 5;   7:  return v / 7;   9:  return v / 9;
      11: return v / 11;  13: return v / 13;  15: return v / 15;  17: return v / 17;
      19: return v / 19;  21: return v / 21;  23: return v / 23;  25: return v / 25;
      27: return v / 27;  29: return v / 29;  31: return v / 31;  33: return v / 33;
      35: return v / 35;  37: return v / 37;  39: return v / 39;  41: return v / 41;
      43: return v / 43;  45: return v / 45;  47: return v / 47;  49: return v / 49;
      51: return v / 51;  53: return v / 53;  55: return v / 55;  57: return v / 57;
      59: return v / 59;
      default: return v;
    endcase
  endfunction

  // atan(2^-j) with 60 fraction bits, truncated series terms
  function automatic logic [63:0] atan_pow(input int unsigned j);
    logic [63:0]  sum;
    logic [63:0]  term;
    int unsigned  k;
    logic         add;
    sum = 64'd0;
    add = 1'b1;
    if (j == 0) begin
      return PI_QUARTER_Q60;
    end
    for (k = 1; k <= 59; k += 2) begin
      if (j * k <= 60) begin
        term = odd_div(64'd1 << (60 - j * k), k);
        sum  = add ? sum + term : sum - term;
        add  = !add;
      end
    end
    return sum;
  endfunction

  // arctangent rounded to nearest at frac fraction bits
  function automatic logic [63:0] atan_fixed(input int unsigned j, input int unsigned frac);
    logic [63:0] full;
    full = atan_pow(j);
    return (full + (64'd1 << (59 - frac))) >> (60 - frac);
  endfunction

endpackage

>>> rtl/crv_cfg_regs.sv
// gain correction registers written through the plain write port
// depends on crv_pkg
module crv_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [crv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crv_pkg::CFG_DATA_W-1:0]    cfg_data,
  output crv_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count <= crv_pkg::COUNT_RESET;
      cfg.shift[0]   <= crv_pkg::SHIFT_A_RESET;
      cfg.shift[1]   <= crv_pkg::SHIFT_B_RESET;
      cfg.shift[2]   <= crv_pkg::SHIFT_C_RESET;
      cfg.shift[3]   <= crv_pkg::SHIFT_D_RESET;
    end else if (cfg_write) begin
      case (crv_pkg::cfg_reg_t'(cfg_index))
        crv_pkg::REG_STEP_COUNT: cfg.step_count <= cfg_data[crv_pkg::COUNT_W-1:0];
        crv_pkg::REG_SHIFT_A:    cfg.shift[0]   <= cfg_data[crv_pkg::SHIFT_W-1:0];
        crv_pkg::REG_SHIFT_B:    cfg.shift[1]   <= cfg_data[crv_pkg::SHIFT_W-1:0];
        crv_pkg::REG_SHIFT_C:    cfg.shift[2]   <= cfg_data[crv_pkg::SHIFT_W-1:0];
        crv_pkg::REG_SHIFT_D:    cfg.shift[3]   <= cfg_data[crv_pkg::SHIFT_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

endmodule

>>> rtl/crv_micro_rot.sv
// one registered cordic micro-rotation with a fixed shift and angle constant
// depends on crv_pkg for the arctangent builder
module crv_micro_rot #(
  parameter int DATA_WIDTH = crv_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = crv_pkg::FRAC_BITS,
  parameter int STEP       = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_in,
  input  logic                         mode_in,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  input  logic signed [DATA_WIDTH-1:0] y_in,
  input  logic signed [DATA_WIDTH-1:0] z_in,
  output logic                         valid,
  output logic                         mode,
  output logic signed [DATA_WIDTH-1:0] x,
  output logic signed [DATA_WIDTH-1:0] y,
  output logic signed [DATA_WIDTH-1:0] z
);

  localparam logic [63:0] ANGLE_RND = crv_pkg::atan_fixed(STEP, FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] ANGLE = DATA_WIDTH'(ANGLE_RND);

  logic signed [DATA_WIDTH-1:0] xs;
  logic signed [DATA_WIDTH-1:0] ys;
  logic                         up;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;
  // vectoring steers y toward zero, rotation steers the residual angle
  assign up = mode_in ? y_in[DATA_WIDTH-1] : ~z_in[DATA_WIDTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    mode <= mode_in;
    if (up) begin
      x <= x_in - ys;
      y <= y_in + xs;
      z <= z_in - ANGLE;
    end else begin
      x <= x_in + ys;
      y <= y_in - xs;
      z <= z_in + ANGLE;
    end
  end

endmodule

>>> rtl/crv_gain_stage.sv
// one registered shift-and-add gain correction step, x += x >> s
// depends on crv_pkg for the configuration struct
module crv_gain_stage #(
  parameter int DATA_WIDTH = crv_pkg::DATA_WIDTH,
  parameter int STEP_IDX   = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  crv_pkg::cfg_t                cfg,
  input  logic                         valid_in,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  input  logic signed [DATA_WIDTH-1:0] y_in,
  input  logic signed [DATA_WIDTH-1:0] z_in,
  output logic                         valid,
  output logic signed [DATA_WIDTH-1:0] x,
  output logic signed [DATA_WIDTH-1:0] y,
  output logic signed [DATA_WIDTH-1:0] z
);

  localparam logic [crv_pkg::COUNT_W-1:0] IDX = crv_pkg::COUNT_W'(STEP_IDX);

  logic                          apply;
  logic [crv_pkg::SHIFT_W-1:0]   sh;

  // a count above the stage total simply enables every stage
  assign apply = cfg.step_count > IDX;
  assign sh    = cfg.shift[STEP_IDX];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    z <= z_in;
    if (apply) begin
      x <= x_in + (x_in >>> sh);
      y <= y_in + (y_in >>> sh);
    end else begin
      x <= x_in;
      y <= y_in;
    end
  end

endmodule

>>> rtl/cordic_rotate_vector.sv
// cordic rotation/vectoring pipeline, top level
// depends on crv_pkg, crv_cfg_regs, crv_micro_rot, crv_gain_stage
//
// Takes one item per clock whenever start is high; busy is never raised. Each item runs
// through ITERATIONS micro-rotation stages (one per arctangent constant) and then
// MAX_SCALE_STEPS gain correction stages, one register each, so the result appears on
// end_x, end_y and end_angle with done high once the item leaves the last gain stage,
// for one cycle only. The receiver cannot hold results off, so it must take every done
// cycle. Angles use FRAC_BITS fraction bits; all arithmetic wraps at DATA_WIDTH bits.
// Write the gain registers only while no item is in flight.
module cordic_rotate_vector #(
  parameter int ITERATIONS      = crv_pkg::ITERATIONS,
  parameter int MAX_SCALE_STEPS = crv_pkg::MAX_SCALE_STEPS,
  parameter int DATA_WIDTH      = crv_pkg::DATA_WIDTH,
  parameter int FRAC_BITS       = crv_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [crv_pkg::FIELD_W-1:0]  start_x,
  input  logic signed [crv_pkg::FIELD_W-1:0]  start_y,
  input  logic signed [crv_pkg::FIELD_W-1:0]  rotate_angle,
  input  logic                                vector_mode,
  output logic                                done,
  output logic signed [crv_pkg::FIELD_W-1:0]  end_x,
  output logic signed [crv_pkg::FIELD_W-1:0]  end_y,
  output logic signed [crv_pkg::FIELD_W-1:0]  end_angle,
  input  logic                                cfg_write,
  input  logic [crv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  crv_pkg::cfg_t cfg;

  logic                         rv [0:ITERATIONS];
  logic                         rm [0:ITERATIONS];
  logic signed [DATA_WIDTH-1:0] rx [0:ITERATIONS];
  logic signed [DATA_WIDTH-1:0] ry [0:ITERATIONS];
  logic signed [DATA_WIDTH-1:0] rz [0:ITERATIONS];

  logic                         gv [0:MAX_SCALE_STEPS];
  logic signed [DATA_WIDTH-1:0] gx [0:MAX_SCALE_STEPS];
  logic signed [DATA_WIDTH-1:0] gy [0:MAX_SCALE_STEPS];
  logic signed [DATA_WIDTH-1:0] gz [0:MAX_SCALE_STEPS];

  // every stage advances each cycle, so the pipeline never refuses an item
  assign busy = 1'b0;

  crv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // size casts sign extend or wrap the 32-bit fields to the datapath width
  assign rv[0] = start & ~busy;
  assign rm[0] = vector_mode;
  assign rx[0] = DATA_WIDTH'(start_x);
  assign ry[0] = DATA_WIDTH'(start_y);
  assign rz[0] = vector_mode ? '0 : DATA_WIDTH'(rotate_angle);

  for (genvar j = 0; j < ITERATIONS; j++) begin : g_rot
    crv_micro_rot #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .STEP       (j)
    ) u_rot (
      .clk      (clk),
      .rst      (rst),
      .valid_in (rv[j]),
      .mode_in  (rm[j]),
      .x_in     (rx[j]),
      .y_in     (ry[j]),
      .z_in     (rz[j]),
      .valid    (rv[j+1]),
      .mode     (rm[j+1]),
      .x        (rx[j+1]),
      .y        (ry[j+1]),
      .z        (rz[j+1])
    );
  end

  assign gv[0] = rv[ITERATIONS];
  assign gx[0] = rx[ITERATIONS];
  assign gy[0] = ry[ITERATIONS];
  assign gz[0] = rz[ITERATIONS];

  for (genvar i = 0; i < MAX_SCALE_STEPS; i++) begin : g_gain
    crv_gain_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .STEP_IDX   (i)
    ) u_gain (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .valid_in (gv[i]),
      .x_in     (gx[i]),
      .y_in     (gy[i]),
      .z_in     (gz[i]),
      .valid    (gv[i+1]),
      .x        (gx[i+1]),
      .y        (gy[i+1]),
      .z        (gz[i+1])
    );
  end

  assign done      = gv[MAX_SCALE_STEPS];
  assign end_x     = crv_pkg::FIELD_W'(gx[MAX_SCALE_STEPS]);
  assign end_y     = crv_pkg::FIELD_W'(gy[MAX_SCALE_STEPS]);
  assign end_angle = crv_pkg::FIELD_W'(gz[MAX_SCALE_STEPS]);

endmodule
